[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, item kind codes, the queued command type and the FSM states.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Field widths of the input and result items
	localparam int KIND_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 11;
	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int ATTR_W  = 8;
	localparam int ENTRY_W = 16;

	// Item kind codes
	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	// Special character codes
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

	// Attribute after reset
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

	// Command queue depth
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = 1;
	localparam int FIFO_CNT_W = 2;

	// Classified operation
	typedef enum logic [2:0] {
		OP_PUT,
		OP_NEWLINE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] char_code;
		logic [ADDR_W-1:0] cell_address;
	} cmd_t;

	// Back end states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COPY,
		ST_FILL
	} st_t;

endpackage

[rtl/tcw_if.sv]
// ----------------------------------------------------------------------------
// tcw_if: item channels of the text console writer
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface tcw_in_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [CHAR_W-1:0] char_code;
	logic [ADDR_W-1:0] cell_address;

	modport source (output valid, kind, char_code, cell_address, input ready);
	modport sink   (input valid, kind, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
	import tcw_pkg::*;

	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   cursor_row;
	logic [COL_W-1:0]   cursor_column;
	logic               scrolled;
	logic [ENTRY_W-1:0] cell_entry;

	modport source (output valid, cursor_row, cursor_column, scrolled, cell_entry,
		input ready);
	modport sink   (input valid, cursor_row, cursor_column, scrolled, cell_entry,
		output ready);
endinterface

[rtl/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front: input item classifier
// Accepts input items while the queue has room and turns each into a command.
// ----------------------------------------------------------------------------
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	tcw_in_if.sink        in_ch,
	input  logic          full,
	output logic          push,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	localparam int CELLS = ROWS * COLUMNS;

	logic addr_ok;

	// Accept while the queue has room
	assign in_ch.ready = ~full;
	assign push        = in_ch.valid & ~full;

	assign addr_ok = 32'(in_ch.cell_address) < CELLS;

	// Classify the item
	always_comb begin
		cmd.char_code    = in_ch.char_code;
		cmd.cell_address = in_ch.cell_address;
		unique case (in_ch.kind)
			KIND_PUT: begin
				cmd.op = (in_ch.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
			end
			KIND_CLEAR: begin
				cmd.op = OP_CLEAR;
			end
			KIND_READ: begin
				cmd.op = addr_ok ? OP_READ : OP_NOP;
			end
			default: begin
				cmd.op = OP_NOP;
			end
		endcase
	end

endmodule

[rtl/tcw_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// tcw_cmd_fifo: command queue
// Short queue between the classifier and the executor.
// ----------------------------------------------------------------------------
module tcw_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tcw_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output tcw_pkg::cmd_t rdata
);
	import tcw_pkg::*;

	cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
	assign valid = count_q != '0;
	assign rdata = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back: command executor
// Owns the screen store and the cursor; runs puts, reads, scrolls and clears.
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  tcw_pkg::cmd_t                 cmd,
	output logic                          cmd_pop,
	input  logic [tcw_pkg::ATTR_W-1:0]    text_attribute,
	tcw_out_if.source                     out_ch
);
	import tcw_pkg::*;

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int AW         = $clog2(CELLS);
	localparam int RW         = $clog2(ROWS);
	localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int COPY_LAST  = CELLS - COLUMNS - 1;
	localparam int FILL_START = (ROWS - 1) * COLUMNS;

	// Screen store and its port
	logic [ENTRY_W-1:0] mem [CELLS];
	logic [ENTRY_W-1:0] rdata_q;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;

	// Control state
	st_t                state_q, state_d;
	logic [RW-1:0]      row_q;
	logic [CW-1:0]      col_q;
	logic [AW-1:0]      cnt_q;
	logic [ENTRY_W-1:0] fill_data_q;
	logic               emit_q;
	logic               scroll_pend_q;
	logic               copy_pend_s1;
	logic [AW-1:0]      copy_addr_s1;
	logic               out_valid_q;
	logic               scrolled_q;
	logic [ENTRY_W-1:0] entry_q;

	// Cursor arithmetic
	logic [AW-1:0]      cur_idx;
	logic [CW:0]        col_inc;
	logic [RW:0]        row_inc;
	logic               line_end;
	logic               overflow;
	logic               copy_last;
	logic               fill_last;
	logic [ENTRY_W-1:0] blank;

	assign cur_idx   = AW'(row_q * COLUMNS) + AW'(col_q);
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign row_inc   = {1'b0, row_q} + 1'b1;
	assign line_end  = (cmd.op == OP_NEWLINE) || (col_inc == (CW+1)'(COLUMNS));
	assign overflow  = line_end && (row_inc == (RW+1)'(ROWS));
	assign copy_last = cnt_q == AW'(COPY_LAST);
	assign fill_last = cnt_q == AW'(CELLS - 1);
	assign blank     = {text_attribute, SPACE_CODE};

	// Take a command only with the result register empty
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;

	// Result channel
	assign out_ch.valid         = out_valid_q;
	assign out_ch.cursor_row    = ROW_W'(row_q);
	assign out_ch.cursor_column = COL_W'(col_q);
	assign out_ch.scrolled      = scrolled_q;
	assign out_ch.cell_entry    = entry_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					unique case (cmd.op) inside
						OP_READ:  state_d = ST_READ;
						OP_CLEAR: state_d = ST_FILL;
						OP_PUT, OP_NEWLINE: begin
							state_d = overflow ? ST_COPY : ST_IDLE;
						end
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			ST_COPY: begin
				if (copy_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (!copy_pend_s1 && fill_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = fill_data_q;
		mem_raddr = AW'(cmd.cell_address);
		if (state_q == ST_COPY) begin
			mem_raddr = cnt_q + AW'(COLUMNS);
		end
		if (copy_pend_s1) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_s1;
			mem_wdata = rdata_q;
		end else if (cmd_pop && cmd.op == OP_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = cur_idx;
			mem_wdata = {text_attribute, cmd.char_code};
		end else if (state_q == ST_FILL) begin
			mem_we = 1'b1;
		end
	end

	// Screen store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Copy write pipeline and result payload
	always_ff @(posedge clk) begin
		copy_addr_s1 <= cnt_q;
		if (cmd_pop) begin
			scrolled_q <= 1'b0;
			entry_q    <= '0;
		end else if (state_q == ST_READ) begin
			entry_q <= rdata_q;
		end else if (state_q == ST_FILL && !copy_pend_s1 && fill_last) begin
			scrolled_q <= scroll_pend_q;
		end
	end

	// State, cursor and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_FILL;
			row_q         <= '0;
			col_q         <= '0;
			cnt_q         <= '0;
			fill_data_q   <= '0;
			emit_q        <= 1'b0;
			scroll_pend_q <= 1'b0;
			copy_pend_s1  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			copy_pend_s1 <= state_q == ST_COPY;
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						unique case (cmd.op) inside
							OP_PUT, OP_NEWLINE: begin
								if (line_end) begin
									col_q <= '0;
									row_q <= overflow ? RW'(ROWS - 1) : row_inc[RW-1:0];
								end else begin
									col_q <= col_inc[CW-1:0];
								end
								if (overflow) begin
									cnt_q         <= '0;
									fill_data_q   <= blank;
									emit_q        <= 1'b1;
									scroll_pend_q <= 1'b1;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								row_q         <= '0;
								col_q         <= '0;
								cnt_q         <= '0;
								fill_data_q   <= blank;
								emit_q        <= 1'b1;
								scroll_pend_q <= 1'b0;
							end
							OP_READ: begin
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
				end
				ST_COPY: begin
					cnt_q <= copy_last ? AW'(FILL_START) : cnt_q + 1'b1;
				end
				ST_FILL: begin
					if (!copy_pend_s1) begin
						cnt_q <= cnt_q + 1'b1;
						if (fill_last) begin
							out_valid_q <= emit_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[rtl/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console engine
// Put, newline, read of a bad address and unused kind give their result
//   from the result register; an in-range read first passes the READ state.
// A command is taken only with the executor idle and the result register
//   drained, so no new command starts before the last one has finished.
// A scroll copies rows up and blanks the bottom row; a clear blanks all cells.
// Reset: cursor homes, attribute 7, and a clearing pass zeroes every cell of
//   the store; up to two items queue meanwhile, config is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata,
	tcw_in_if.sink                     in_ch,
	tcw_out_if.source                  out_ch
);
	import tcw_pkg::*;

	logic [ATTR_W-1:0] text_attribute_q;
	cmd_t              push_cmd;
	cmd_t              pop_cmd;
	logic              push;
	logic              full;
	logic              pop;
	logic              cmd_valid;

	// Attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_attribute_q <= ATTR_RESET;
		end else if (cfg_we) begin
			text_attribute_q <= cfg_wdata;
		end
	end

	tcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.in_ch (in_ch),
		.full  (full),
		.push  (push),
		.cmd   (push_cmd)
	);

	tcw_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.full   (full),
		.pop    (pop),
		.valid  (cmd_valid),
		.rdata  (pop_cmd)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd            (pop_cmd),
		.cmd_pop        (pop),
		.text_attribute (text_attribute_q),
		.out_ch         (out_ch)
	);

endmodule

[rtl/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker: port checks of the text console writer
// Watches the result channel for hold behavior and consistent cursor values.
// ----------------------------------------------------------------------------
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [tcw_pkg::ROW_W-1:0]   cursor_row,
	input logic [tcw_pkg::COL_W-1:0]   cursor_column,
	input logic                        scrolled,
	input logic [tcw_pkg::ENTRY_W-1:0] cell_entry
);
	import tcw_pkg::*;

	// Hold a stalled item
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cell_entry) && $stable(scrolled))
		else $error("result payload changed while stalled");

	// Cursor column stays on screen
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(cursor_column) < COLUMNS || COLUMNS > (1 << COL_W))
		else $error("cursor column beyond last column");

	// A scroll leaves the cursor at the start of the bottom row
	a_scroll_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |->
			cursor_row == ROW_W'(ROWS - 1) && cursor_column == '0)
		else $error("scroll left cursor off the bottom row start");

	a_scroll_entry: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled |-> cell_entry == '0)
		else $error("scroll result carries cell data");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.cursor_row    (out_ch.cursor_row),
	.cursor_column (out_ch.cursor_column),
	.scrolled      (out_ch.scrolled),
	.cell_entry    (out_ch.cell_entry)
);

[bench/text_console_writer_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test: self-checking bench for the text console writer
// Sends put, newline, clear, read and unused-kind items. A shadow screen with
// its own cursor and attribute works out the cursor, scroll flag and cell
// contents for each item. Every result item is checked in order, across
// several attribute settings and idling patterns on both channels.
// ----------------------------------------------------------------------------
module text_console_writer_test;
	import tcw_pkg::*;

	localparam int SCREEN_COLS    = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_COLS * SCREEN_ROWS;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_ITEMS    = 160;
	localparam int SETTLE_CYCLES  = 2200;
	localparam int WATCHDOG_LIMIT = 20000;

	// Kind code that the block leaves undefined
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] char_code;
		logic [ADDR_W-1:0] cell_address;
	} console_cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0]   cursor_row;
		logic [COL_W-1:0]   cursor_column;
		logic               scrolled;
		logic [ENTRY_W-1:0] cell_entry;
	} console_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [ATTR_W-1:0]  cfg_wdata = '0;
	logic               drv_valid = 1'b0;
	logic [KIND_W-1:0]  drv_kind  = '0;
	logic [CHAR_W-1:0]  drv_char  = '0;
	logic [ADDR_W-1:0]  drv_addr  = '0;
	logic               rcv_ready = 1'b0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int          error_count    = 0;
	int          idle_cycles    = 0;

	console_cmd_t    pending_cmds[$];
	console_result_t expected_results[$];

	// Shadow copy of the console state
	logic [ENTRY_W-1:0] shadow_cells [CELL_COUNT];
	int                 shadow_row  = 0;
	int                 shadow_col  = 0;
	logic [ATTR_W-1:0]  shadow_attr = ATTR_RESET;

	tcw_in_if  in_ch ();
	tcw_out_if out_ch ();

	assign in_ch.valid        = drv_valid;
	assign in_ch.kind         = drv_kind;
	assign in_ch.char_code    = drv_char;
	assign in_ch.cell_address = drv_addr;
	assign out_ch.ready       = rcv_ready;

	text_console_writer #(
		.COLUMNS (SCREEN_COLS),
		.ROWS    (SCREEN_ROWS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Move the cursor to the next row; scroll when it passes the bottom
	function automatic logic advance_row();
		logic [ENTRY_W-1:0] blank;
		blank = {shadow_attr, SPACE_CODE};
		shadow_col = 0;
		shadow_row++;
		if (shadow_row < SCREEN_ROWS)
			return 1'b0;
		for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
			shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
		for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
			shadow_cells[i] = blank;
		shadow_row = SCREEN_ROWS - 1;
		return 1'b1;
	endfunction

	// Apply one command to the shadow screen and return its result
	function automatic console_result_t next_console_result(input console_cmd_t cmd);
		console_result_t res;
		res = '0;
		case (cmd.kind)
			KIND_PUT: begin
				if (cmd.char_code == NEWLINE_CODE) begin
					res.scrolled = advance_row();
				end else begin
					shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = {shadow_attr, cmd.char_code};
					shadow_col++;
					if (shadow_col >= SCREEN_COLS)
						res.scrolled = advance_row();
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < CELL_COUNT; i++)
					shadow_cells[i] = {shadow_attr, SPACE_CODE};
				shadow_row = 0;
				shadow_col = 0;
			end
			KIND_READ: begin
				if (cmd.cell_address < CELL_COUNT)
					res.cell_entry = shadow_cells[cmd.cell_address];
			end
			default: begin
			end
		endcase
		res.cursor_row    = ROW_W'(shadow_row);
		res.cursor_column = COL_W'(shadow_col);
		return res;
	endfunction

	function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
		input logic [CHAR_W-1:0] char_code, input logic [ADDR_W-1:0] cell_address);
		pending_cmds.push_back('{kind: kind, char_code: char_code, cell_address: cell_address});
	endfunction

	// Wait until all results are in and any scroll or clear has finished
	task automatic settle();
		while (pending_cmds.size() > 0 || drv_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [ATTR_W-1:0] value);
		cfg_we      <= 1'b1;
		cfg_wdata   <= value;
		shadow_attr  = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Fill one phase with text lines, newline runs, read-backs and noise
	task automatic queue_random_phase(input int quota);
		int                done;
		int                len;
		int                pick;
		int                near;
		logic [ADDR_W-1:0] addr;
		done = 0;
		while (done < quota) begin
			pick = int'($urandom_range(99));
			if (pick < 45) begin
				// text line, mostly short, sometimes wrapping past the last column
				len = ($urandom_range(9) == 0) ? int'($urandom_range(100, 70))
					: int'($urandom_range(12));
				for (int i = 0; i < len; i++)
					queue_cmd(KIND_PUT, CHAR_W'($urandom_range(255)), ADDR_W'($urandom_range(2047)));
				if ($urandom_range(4) != 0) begin
					queue_cmd(KIND_PUT, NEWLINE_CODE, ADDR_W'($urandom_range(2047)));
					len++;
				end
				done += len;
			end else if (pick < 60) begin
				// run of newlines to push the cursor toward the bottom row
				len = int'($urandom_range(30, 1));
				for (int i = 0; i < len; i++)
					queue_cmd(KIND_PUT, NEWLINE_CODE, ADDR_W'($urandom_range(2047)));
				done += len;
			end else if (pick < 88) begin
				// read back, often just behind the cursor
				len = int'($urandom_range(4, 1));
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(9))
						0, 1, 2, 3: begin
							near = shadow_row * SCREEN_COLS + shadow_col + CELL_COUNT
								- int'($urandom_range(8, 1));
							addr = ADDR_W'(near % CELL_COUNT);
						end
						4, 5, 6: addr = ADDR_W'($urandom_range(CELL_COUNT - 1));
						7: addr = ADDR_W'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 2 * SCREEN_COLS));
						8: addr = ADDR_W'($urandom_range(2047));
						default: begin
							case ($urandom_range(3))
								0: addr = '0;
								1: addr = ADDR_W'(CELL_COUNT - 1);
								2: addr = ADDR_W'(CELL_COUNT);
								default: addr = '1;
							endcase
						end
					endcase
					queue_cmd(KIND_READ, CHAR_W'($urandom_range(255)), addr);
				end
				done += len;
			end else if (pick < 94) begin
				queue_cmd(KIND_PUT, CHAR_W'($urandom_range(255)), ADDR_W'($urandom_range(2047)));
				done++;
			end else if (pick < 98) begin
				// unused kind: leaves screen and cursor unchanged, not counted
				queue_cmd(KIND_UNUSED, CHAR_W'($urandom_range(255)), ADDR_W'($urandom_range(2047)));
			end else begin
				queue_cmd(KIND_CLEAR, CHAR_W'($urandom_range(255)), ADDR_W'($urandom_range(2047)));
				done++;
			end
			// hold generation so read addresses track the live cursor
			while (pending_cmds.size() > 4)
				@(posedge clk);
		end
	endtask

	// Drive input items; predict each accepted one
	always @(posedge clk) begin : drive_items
		console_cmd_t cmd;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && in_ch.ready)
				expected_results.push_back(next_console_result({drv_kind, drv_char, drv_addr}));
			if (!drv_valid || in_ch.ready) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cmd = pending_cmds.pop_front();
					drv_valid <= 1'b1;
					drv_kind  <= cmd.kind;
					drv_char  <= cmd.char_code;
					drv_addr  <= cmd.cell_address;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Check result items, randomize ready, watch for a hang
	always @(posedge clk) begin : check_results
		console_result_t want;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (out_ch.valid && rcv_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item with no item pending: row %0d column %0d",
						out_ch.cursor_row, out_ch.cursor_column);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (out_ch.cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, got %0d", want.cursor_row, out_ch.cursor_row);
						error_count++;
					end
					if (out_ch.cursor_column !== want.cursor_column) begin
						$error("cursor_column: expected %0d, got %0d",
							want.cursor_column, out_ch.cursor_column);
						error_count++;
					end
					if (out_ch.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0d, got %0d", want.scrolled, out_ch.scrolled);
						error_count++;
					end
					if (out_ch.cell_entry !== want.cell_entry) begin
						$error("cell_entry: expected %h, got %h", want.cell_entry, out_ch.cell_entry);
						error_count++;
					end
				end
			end
			rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
			if ((drv_valid && in_ch.ready) || (out_ch.valid && rcv_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("text_console_writer_test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [ATTR_W-1:0] attr;
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_cells[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, address bounds, byte extremes, unused kind
		queue_cmd(KIND_READ, 8'h00, '0);
		queue_cmd(KIND_READ, 8'hFF, ADDR_W'(CELL_COUNT - 1));
		queue_cmd(KIND_READ, 8'h00, ADDR_W'(CELL_COUNT));
		queue_cmd(KIND_READ, 8'h00, '1);
		queue_cmd(KIND_PUT, 8'h00, '1);
		queue_cmd(KIND_PUT, 8'hFF, '0);
		queue_cmd(KIND_PUT, 8'h80, '0);
		queue_cmd(KIND_PUT, 8'h41, '0);
		queue_cmd(KIND_UNUSED, 8'hFF, '1);
		for (int i = 0; i < 4; i++)
			queue_cmd(KIND_READ, 8'h00, ADDR_W'(i));
		queue_cmd(KIND_PUT, NEWLINE_CODE, '0);
		queue_cmd(KIND_READ, 8'h00, ADDR_W'(SCREEN_COLS));
		queue_cmd(KIND_CLEAR, 8'hFF, '1);
		queue_cmd(KIND_READ, 8'h00, '0);
		queue_cmd(KIND_READ, 8'h00, ADDR_W'(CELL_COUNT - 1));

		// Random phases, each setting its attribute and idling pattern
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			case (p)
				0: attr = 8'h00;
				1: attr = 8'hFF;
				PHASE_COUNT - 1: attr = ATTR_RESET;
				default: attr = ATTR_W'($urandom_range(255));
			endcase
			write_attribute(attr);
			case (p % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 53;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 53;
				end
				default: begin
					send_idle_pct  = 8;
					recv_stall_pct = 8;
				end
			endcase
			queue_random_phase(PHASE_ITEMS);
		end

		settle();
		if (error_count == 0)
			$display("text_console_writer_test passed");
		else
			$display("text_console_writer_test failed");
		$finish;
	end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_if.sv
rtl/tcw_front.sv
rtl/tcw_cmd_fifo.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
rtl/tcw_checker.sv
bench/text_console_writer_test.sv
